// ----- sv/mnpt_pkg.sv -----
// ----------------------------------------------------------------------------
// mnpt_pkg
// Shared types and constants of the masked nearest-point table.
// ----------------------------------------------------------------------------
package mnpt_pkg;

	// default geometry of the table
	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_COORD_BITS    = 20;

	// fixed field widths
	localparam int SLOT_W     = 6;
	localparam int FLAG_W     = 32;
	localparam int DIST_OUT_W = 44;
	localparam int ACTION_W   = 2;

	// result beat: found, hit_slot, distance_sq, padded to whole bytes
	localparam int OUT_FIELDS_W = 1 + SLOT_W + DIST_OUT_W;
	localparam int OUT_TW       = ((OUT_FIELDS_W + 7) / 8) * 8;

	// operation carried in s_tuser
	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE      = 2'd0,
		ACT_REMOVE     = 2'd1,
		ACT_FIND_FIRST = 2'd2,
		ACT_NEAREST    = 2'd3
	} action_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ----- sv/masked_nearest_point_table_core.sv -----
// ----------------------------------------------------------------------------
// masked_nearest_point_table_core
// Table of 3-D points with flag words; writes, removes, first-by-mask search
// and nearest-point search by a linear sweep of the entry memory.
// ----------------------------------------------------------------------------
//
//  channel  dir  signals                 content
//  -------  ---  ----------------------  ----------------------------------------
//  s_*      in   tvalid tready tdata     slot, pos_x, pos_y, pos_z, flag_bits
//                tuser                   action
//  m_*      out  tvalid tready tdata     found, hit_slot, distance_sq
//
//  write and remove go on to the finish state, which loads the result register
//  once it is free. both searches read one entry per cycle from the single-port
//  entry memory; the result register loads after the memory sweep through the
//  read, difference, square and sum stages, the compare and the finish state.
//  after reset a clearing pass over all entries zeroes the valid bits;
//  s_tready stays low until it is done.
//  one item is in work at a time; the next beat is taken while a result
//  waits in the output register, and a finished result waits there if
//  m_tready is low.
//
module masked_nearest_point_table_core
	import mnpt_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int COORD_BITS    = DEF_COORD_BITS
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// slot, pos_x, pos_y, pos_z, flag_bits, zero pad (lowest bit up)
	input  logic [((SLOT_W + 3 * COORD_BITS + FLAG_W + 7) / 8) * 8 - 1:0] s_tdata,
	// action
	input  logic [ACTION_W-1:0] s_tuser,

	output logic m_tvalid,
	input  logic m_tready,
	// found, hit_slot, distance_sq, zero pad (lowest bit up)
	output logic [OUT_TW-1:0] m_tdata
);

	localparam int CB    = COORD_BITS;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int MW    = 1 + FLAG_W + 3 * CB;
	localparam int SQ_W  = 2 * CB + 2;
	localparam int DW    = 2 * CB + 4;
	localparam int DX_W  = (DW > DIST_OUT_W) ? DW : DIST_OUT_W;
	localparam int SX_W  = (IDX_W > SLOT_W) ? IDX_W + 1 : SLOT_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// input field unpacking
	action_t                act;
	logic [SLOT_W-1:0]      in_slot;
	logic [CB-1:0]          in_x, in_y, in_z;
	logic [FLAG_W-1:0]      in_flags;
	logic [SX_W-1:0]        slot_ext;
	logic                   slot_ok;
	logic                   in_fire;

	assign act      = action_t'(s_tuser);
	assign in_slot  = s_tdata[SLOT_W-1:0];
	assign in_x     = s_tdata[SLOT_W +: CB];
	assign in_y     = s_tdata[SLOT_W + CB +: CB];
	assign in_z     = s_tdata[SLOT_W + 2 * CB +: CB];
	assign in_flags = s_tdata[SLOT_W + 3 * CB +: FLAG_W];
	assign slot_ext = SX_W'(in_slot);
	assign slot_ok  = slot_ext < SX_W'(TABLE_ENTRIES);
	assign in_fire  = s_tvalid && s_tready;

	// state and control registers
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]  rd_cnt_q;
	logic              issued_all_q;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic              scan_done;
	logic              issue;
	logic              out_load;
	logic              m_tvalid_q;

	// query registers
	logic [CB-1:0]     qx_q, qy_q, qz_q;
	logic [FLAG_W-1:0] mask_q;
	logic              near_q;

	// memory port signals
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [MW-1:0]     mem_wdata;
	logic [MW-1:0]     mem [TABLE_ENTRIES];

	assign scan_done = issued_all_q && !v_s1 && !v_s2 && !v_s3 && !v_s4;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_IDX) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (act == ACT_FIND_FIRST || act == ACT_NEAREST) state_d = ST_SCAN;
					else state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// state outputs and memory write port
	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = slot_ext[IDX_W-1:0];
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_fire && slot_ok && act == ACT_WRITE) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, in_flags, in_z, in_y, in_x};
				end else if (in_fire && slot_ok && act == ACT_REMOVE) begin
					mem_we = 1'b1;
				end
			end
			ST_SCAN: begin
				issue = !issued_all_q;
			end
			ST_FINISH: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// state, clearing pass and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			rd_cnt_q     <= '0;
			issued_all_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (in_fire) begin
				rd_cnt_q     <= '0;
				issued_all_q <= 1'b0;
			end else if (issue) begin
				if (rd_cnt_q == LAST_IDX) issued_all_q <= 1'b1;
				else rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// query capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			qx_q   <= in_x;
			qy_q   <= in_y;
			qz_q   <= in_z;
			mask_q <= in_flags;
			near_q <= (act == ACT_NEAREST);
		end
	end

	// entry memory: one write port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	// stage 1: registered memory read
	logic [MW-1:0]    rd_s1;
	logic [IDX_W-1:0] idx_s1;

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1  <= mem[rd_cnt_q];
			idx_s1 <= rd_cnt_q;
		end
	end

	// stage 2: mask match and coordinate differences
	logic                   rd_valid;
	logic [FLAG_W-1:0]      rd_flags;
	logic [CB-1:0]          px, py, pz;
	logic signed [CB:0]     dx, dy, dz;
	logic signed [CB:0]     dx_s2, dy_s2, dz_s2;
	logic                   match_s2;
	logic [IDX_W-1:0]       idx_s2;

	assign px       = rd_s1[0 +: CB];
	assign py       = rd_s1[CB +: CB];
	assign pz       = rd_s1[2 * CB +: CB];
	assign rd_flags = rd_s1[3 * CB +: FLAG_W];
	assign rd_valid = rd_s1[MW-1];
	assign dx = $signed({qx_q[CB-1], qx_q}) - $signed({px[CB-1], px});
	assign dy = $signed({qy_q[CB-1], qy_q}) - $signed({py[CB-1], py});
	assign dz = $signed({qz_q[CB-1], qz_q}) - $signed({pz[CB-1], pz});

	always_ff @(posedge clk) begin
		dx_s2    <= dx;
		dy_s2    <= dy;
		dz_s2    <= dz;
		match_s2 <= rd_valid && ((rd_flags & mask_q) != '0);
		idx_s2   <= idx_s1;
	end

	// stage 3: squares; the product bits read as unsigned give the exact square
	logic signed [SQ_W-1:0] px2, py2, pz2;
	logic [SQ_W-1:0]        sx_s3, sy_s3, sz_s3;
	logic                   match_s3;
	logic [IDX_W-1:0]       idx_s3;

	assign px2 = SQ_W'(dx_s2) * SQ_W'(dx_s2);
	assign py2 = SQ_W'(dy_s2) * SQ_W'(dy_s2);
	assign pz2 = SQ_W'(dz_s2) * SQ_W'(dz_s2);

	always_ff @(posedge clk) begin
		sx_s3    <= px2;
		sy_s3    <= py2;
		sz_s3    <= pz2;
		match_s3 <= match_s2;
		idx_s3   <= idx_s2;
	end

	// stage 4: distance sum
	logic [DW-1:0]    dist_s4;
	logic             match_s4;
	logic [IDX_W-1:0] idx_s4;

	always_ff @(posedge clk) begin
		dist_s4  <= DW'(sx_s3) + DW'(sy_s3) + DW'(sz_s3);
		match_s4 <= match_s3;
		idx_s4   <= idx_s3;
	end

	// pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// best-so-far; first match only for find-first, strict less keeps lower slot
	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [DW-1:0]    best_dist_q;
	logic             take;

	assign take = v_s4 && match_s4 &&
		(!best_found_q || (near_q && (dist_s4 < best_dist_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_dist_q  <= '0;
		end else if (in_fire) begin
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_dist_q  <= '0;
		end else if (take) begin
			best_found_q <= 1'b1;
			best_idx_q   <= idx_s4;
			best_dist_q  <= dist_s4;
		end
	end

	// result register
	logic [SX_W-1:0]       hit_ext;
	logic [DX_W-1:0]       dist_ext;
	logic                  m_found_q;
	logic [SLOT_W-1:0]     m_slot_q;
	logic [DIST_OUT_W-1:0] m_dist_q;

	assign hit_ext  = SX_W'(best_idx_q);
	assign dist_ext = DX_W'(best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_found_q <= best_found_q;
			m_slot_q  <= hit_ext[SLOT_W-1:0];
			m_dist_q  <= near_q ? dist_ext[DIST_OUT_W-1:0] : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'({m_dist_q, m_slot_q, m_found_q});

endmodule

// ----- sv/mnpt_checker.sv -----
// ----------------------------------------------------------------------------
// mnpt_checker
// Port-level checks of the masked nearest-point table, bound to the table core.
// ----------------------------------------------------------------------------
module mnpt_checker
	import mnpt_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int COORD_BITS    = DEF_COORD_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	// slot, pos_x, pos_y, pos_z, flag_bits, zero pad (lowest bit up)
	input logic [((SLOT_W + 3 * COORD_BITS + FLAG_W + 7) / 8) * 8 - 1:0] s_tdata,
	// action
	input logic [ACTION_W-1:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	// found, hit_slot, distance_sq, zero pad (lowest bit up)
	input logic [OUT_TW-1:0] m_tdata
);

	localparam int SX_W = 32;

	logic                  r_found;
	logic [SLOT_W-1:0]     r_slot;
	logic [DIST_OUT_W-1:0] r_dist;

	assign r_found = m_tdata[0];
	assign r_slot  = m_tdata[SLOT_W:1];
	assign r_dist  = m_tdata[SLOT_W + DIST_OUT_W:SLOT_W + 1];

	// one item at a time: an accepted beat closes the input for the next cycle
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken twice in a row");

	// a miss carries zero slot and zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !r_found) |-> (r_slot == '0 && r_dist == '0))
		else $error("miss with nonzero payload");

	// a hit names a slot inside the table
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && r_found) |->
		((TABLE_ENTRIES > 64) || (SX_W'(r_slot) < SX_W'(TABLE_ENTRIES))))
		else $error("hit slot beyond table");

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result beat dropped under stall");

	// and its payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result payload changed under stall");

endmodule

bind masked_nearest_point_table_core mnpt_checker #(
	.TABLE_ENTRIES(TABLE_ENTRIES),
	.COORD_BITS(COORD_BITS)
) u_mnpt_checker (.*);
